@@ rtl/core/tcgr_pkg.sv @@
// ----------------------------------------------------------------------------
// tcgr_pkg
// shared types, constants and codes of the text cell glyph renderer
// ----------------------------------------------------------------------------
`default_nettype none

package tcgr_pkg;

    localparam int FONT_GLYPHS = 96;
    localparam int CELL_SIZE   = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

    // gradient divider geometry
    localparam int DIV_NUM_W = 20;
    localparam int DIV_DEN_W = 12;
    localparam int DIV_STEPS = 4;

    // register reset values
    localparam logic [11:0] RST_FB_WIDTH  = 12'd1024;
    localparam logic [11:0] RST_FB_HEIGHT = 12'd768;
    localparam logic [12:0] RST_PITCH     = 13'd1024;

    // character range that has glyphs
    localparam logic [7:0] CHAR_FIRST = 8'd32;
    localparam logic [7:0] CHAR_SPAN  = 8'd95;

    // colors
    localparam logic [23:0] FG_GREEN  = 24'h00ff00;
    localparam logic [23:0] FG_WHITE  = 24'hffffff;
    localparam logic [23:0] BG_BLUE   = 24'h0000ff;
    localparam logic [7:0]  COLOR_OFS = 8'd60;
    localparam logic [19:0] GRAD_SCALE = 20'd128;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    typedef enum logic [2:0] {
        MODE_PLAIN = 3'd0,
        MODE_RED   = 3'd1,
        MODE_GREEN = 3'd2,
        MODE_BLUE  = 3'd3,
        MODE_SOLID = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        REG_FB_WIDTH      = 3'd0,
        REG_FB_HEIGHT     = 3'd1,
        REG_PITCH_WORDS   = 3'd2,
        REG_PALETTE_MODE  = 3'd3,
        REG_CURSOR_ROW    = 3'd4,
        REG_CURSOR_COLUMN = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic        opcode;
        logic [6:0]  glyph_index;
        logic [15:0] font_bits;
        logic [7:0]  char_code;
        logic [7:0]  cell_row;
        logic [7:0]  cell_column;
        logic [3:0]  glyph_line;
    } t_in_item;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [24:0] word_address;
        logic [23:0] color;
        logic        last;
    } t_out_item;

    // one classified render job between front and back
    typedef struct packed {
        logic [15:0] bits;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [3:0]  line;
    } t_job;

endpackage

`default_nettype wire

@@ rtl/core/tcgr_ram.sv @@
// ----------------------------------------------------------------------------
// tcgr_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module tcgr_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 1536,
    parameter int ADDR_W = 11
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output      logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/tcgr_front.sv @@
// ----------------------------------------------------------------------------
// tcgr_front
// accepts items, writes font lines, looks up glyph lines for render jobs
// ----------------------------------------------------------------------------
`default_nettype none

module tcgr_front #(
    parameter int FONT_GLYPHS = tcgr_pkg::FONT_GLYPHS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output      logic                          o_stall,
    input  wire tcgr_pkg::t_in_item            i_item,
    input  wire logic [tcgr_pkg::QCOUNT_W-1:0] i_q_count,
    output      logic                          o_push,
    output      tcgr_pkg::t_job                o_job
);

    localparam int GW    = (FONT_GLYPHS > 1) ? $clog2(FONT_GLYPHS) : 1;
    localparam int AW    = GW + 4;
    localparam int DEPTH = FONT_GLYPHS * tcgr_pkg::CELL_SIZE;
    localparam int QW    = tcgr_pkg::QCOUNT_W;

    logic          w_accept;
    logic          w_printable;
    logic [8:0]    w_code_ofs;
    logic [8:0]    w_glyph;
    logic [8:0]    w_gidx;
    logic          w_load_ok;
    logic          w_we;
    logic          w_re;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    logic [15:0]   w_rdata;
    logic [QW:0]   w_need;

    logic          r_s1_valid;
    logic [7:0]    r_s1_row;
    logic [7:0]    r_s1_col;
    logic [3:0]    r_s1_line;

    // room for whatever is already in flight
    assign w_need   = (QW + 1)'(i_q_count) + (QW + 1)'(r_s1_valid);
    assign o_stall  = (w_need >= (QW + 1)'(tcgr_pkg::QUEUE_DEPTH));
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        w_printable = (i_item.char_code >= tcgr_pkg::CHAR_FIRST) &&
                      (i_item.char_code <= (tcgr_pkg::CHAR_FIRST + tcgr_pkg::CHAR_SPAN));
        w_code_ofs  = {1'b0, i_item.char_code} - {1'b0, tcgr_pkg::CHAR_FIRST};
        w_glyph     = w_printable ? w_code_ofs : 9'd0;
        if (w_glyph >= 9'(FONT_GLYPHS)) begin
            w_glyph = 9'd0;
        end
    end

    assign w_gidx    = {2'b00, i_item.glyph_index};
    assign w_load_ok = (w_gidx < 9'(FONT_GLYPHS));
    assign w_we      = w_accept && (i_item.opcode == tcgr_pkg::OP_LOAD) && w_load_ok;
    assign w_re      = w_accept && (i_item.opcode == tcgr_pkg::OP_RENDER);
    assign w_waddr   = {w_gidx[GW-1:0], i_item.glyph_line};
    assign w_raddr   = {w_glyph[GW-1:0], i_item.glyph_line};

    tcgr_ram #(
        .WIDTH  (16),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_font (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_item.font_bits),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_s1_row  <= i_item.cell_row;
            r_s1_col  <= i_item.cell_column;
            r_s1_line <= i_item.glyph_line;
        end
    end

    assign o_push = r_s1_valid;
    assign o_job  = '{bits: w_rdata, row: r_s1_row, col: r_s1_col, line: r_s1_line};

endmodule

`default_nettype wire

@@ rtl/core/tcgr_queue.sv @@
// ----------------------------------------------------------------------------
// tcgr_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module tcgr_queue (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire tcgr_pkg::t_job                i_job,
    input  wire logic                          i_pop,
    output      tcgr_pkg::t_job                o_job,
    output      logic                          o_valid,
    output      logic [tcgr_pkg::QCOUNT_W-1:0] o_count
);

    localparam int DEPTH = tcgr_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QW    = tcgr_pkg::QCOUNT_W;

    tcgr_pkg::t_job r_slot [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [QW-1:0]  r_count;
    logic           w_pop;

    assign w_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + QW'(i_push) - QW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

    assign o_job   = r_slot[r_rd];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

endmodule

`default_nettype wire

@@ rtl/core/tcgr_div.sv @@
// ----------------------------------------------------------------------------
// tcgr_div
// restoring divider, a few quotient bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tcgr_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [tcgr_pkg::DIV_NUM_W-1:0] i_num,
    input  wire logic [tcgr_pkg::DIV_DEN_W-1:0] i_den,
    output      logic                           o_busy,
    output      logic [tcgr_pkg::DIV_NUM_W-1:0] o_quo,
    output      logic [tcgr_pkg::DIV_DEN_W-1:0] o_rem
);

    localparam int NW  = tcgr_pkg::DIV_NUM_W;
    localparam int DW  = tcgr_pkg::DIV_DEN_W;
    localparam int ST  = tcgr_pkg::DIV_STEPS;
    localparam int CYC = (NW + ST - 1) / ST;
    localparam int CW  = $clog2(CYC + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [NW-1:0] n_num;
    logic [NW-1:0] n_quo;
    logic [DW-1:0] n_rem;

    always_comb begin
        logic [DW:0] v_t;
        n_num = r_num;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int k = 0; k < ST; k++) begin
            v_t   = {n_rem, n_num[NW-1]};
            n_num = {n_num[NW-2:0], 1'b0};
            if (v_t >= {1'b0, r_den}) begin
                n_rem = DW'(v_t - {1'b0, r_den});
                n_quo = {n_quo[NW-2:0], 1'b1};
            end else begin
                n_rem = v_t[DW-1:0];
                n_quo = {n_quo[NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(CYC);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_quo <= '0;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= n_num;
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

@@ rtl/core/tcgr_back.sv @@
// ----------------------------------------------------------------------------
// tcgr_back
// gradient setup and pixel emission for render jobs
// ----------------------------------------------------------------------------
`default_nettype none

module tcgr_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    input  wire tcgr_pkg::t_job       i_q_job,
    output      logic                 o_q_pop,
    input  wire logic [11:0]          i_fb_width,
    input  wire logic [11:0]          i_fb_height,
    input  wire logic [12:0]          i_pitch,
    input  wire logic [2:0]           i_mode,
    input  wire logic [7:0]           i_cur_row,
    input  wire logic [7:0]           i_cur_col,
    output      logic                 o_valid,
    input  wire logic                 i_stall,
    output      tcgr_pkg::t_out_item  o_item
);

    localparam int NW = tcgr_pkg::DIV_NUM_W;
    localparam int DW = tcgr_pkg::DIV_DEN_W;

    typedef enum logic [1:0] {
        DV_EMPTY,
        DV_RUN,
        DV_HOLD
    } t_dv_state;

    t_dv_state r_dv_state;
    logic [11:0] w_w;
    logic [11:0] w_h;
    logic        w_pop;
    logic [11:0] w_y;
    logic [NW-1:0] w_num_x;
    logic [NW-1:0] w_num_y;
    logic          w_bx;
    logic          w_by;
    logic          w_bc;
    logic [NW-1:0] w_qx;
    logic [NW-1:0] w_qy;
    logic [NW-1:0] w_qc;
    logic [DW-1:0] w_rx;
    logic [DW-1:0] w_ry;
    logic [DW-1:0] w_rc;

    logic [11:0] r_dv_x;
    logic [11:0] r_dv_y;
    logic [24:0] r_dv_base;
    logic [15:0] r_dv_bits;
    logic [3:0]  r_dv_line;
    logic        r_dv_cursor;

    logic        r_em_active;
    logic [3:0]  r_em_p;
    logic [11:0] r_em_x;
    logic [11:0] r_em_y;
    logic [24:0] r_em_addr;
    logic [15:0] r_em_bits;
    logic [NW-1:0] r_em_qx;
    logic [DW-1:0] r_em_rx;
    logic [7:0]    r_em_qa;
    logic [DW-1:0] r_em_ra;
    logic [NW-1:0] r_em_qy;
    logic [3:0]  r_em_line;
    logic        r_em_cursor;

    logic                r_out_valid;
    tcgr_pkg::t_out_item r_out_item;

    logic        w_out_free;
    logic        w_fire;
    logic        w_em_end;
    logic        w_hand;
    logic [DW:0] w_rsum;
    logic [NW:0] w_red_sum;
    logic [NW:0] w_blue_sum;
    logic [7:0]  w_red;
    logic [7:0]  w_green;
    logic [7:0]  w_blue;
    logic [23:0] w_fg;
    logic [23:0] w_bg;
    logic        w_outline;
    logic [23:0] w_color;

    assign w_w = (i_fb_width == '0) ? 12'd1 : i_fb_width;
    assign w_h = (i_fb_height == '0) ? 12'd1 : i_fb_height;

    assign w_pop   = i_q_valid && (r_dv_state == DV_EMPTY);
    assign o_q_pop = w_pop;
    assign w_y     = {i_q_job.row, i_q_job.line};
    assign w_num_x = {1'b0, i_q_job.col, 11'b0};
    assign w_num_y = {1'b0, w_y, 7'b0};

    tcgr_div u_div_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_pop),
        .i_num (w_num_x), .i_den (w_w),
        .o_busy (w_bx), .o_quo (w_qx), .o_rem (w_rx)
    );

    tcgr_div u_div_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_pop),
        .i_num (w_num_y), .i_den (w_h),
        .o_busy (w_by), .o_quo (w_qy), .o_rem (w_ry)
    );

    tcgr_div u_div_step (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_pop),
        .i_num (tcgr_pkg::GRAD_SCALE), .i_den (w_w),
        .o_busy (w_bc), .o_quo (w_qc), .o_rem (w_rc)
    );

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_fire     = r_em_active && w_out_free;
    assign w_em_end   = w_fire && (r_em_p == 4'd15);
    assign w_hand     = (r_dv_state == DV_HOLD) && (!r_em_active || w_em_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_state  <= DV_EMPTY;
            r_em_active <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_dv_state)
                DV_EMPTY: begin
                    if (w_pop) begin
                        r_dv_state <= DV_RUN;
                    end
                end
                DV_RUN: begin
                    if (!w_bx && !w_by && !w_bc) begin
                        r_dv_state <= DV_HOLD;
                    end
                end
                DV_HOLD: begin
                    if (w_hand) begin
                        r_dv_state <= DV_EMPTY;
                    end
                end
                default: begin
                    r_dv_state <= DV_EMPTY;
                end
            endcase
            if (w_hand) begin
                r_em_active <= 1'b1;
            end else if (w_em_end) begin
                r_em_active <= 1'b0;
            end
            if (w_out_free) begin
                r_out_valid <= w_fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_dv_x      <= {i_q_job.col, 4'b0};
            r_dv_y      <= w_y;
            r_dv_base   <= 25'(w_y) * 25'(i_pitch);
            r_dv_bits   <= i_q_job.bits;
            r_dv_line   <= i_q_job.line;
            r_dv_cursor <= (i_q_job.row == i_cur_row) && (i_q_job.col == i_cur_col);
        end
    end

    assign w_rsum = {1'b0, r_em_rx} + {1'b0, r_em_ra};

    always_ff @(posedge i_clk) begin
        if (w_hand) begin
            r_em_p      <= 4'd0;
            r_em_x      <= r_dv_x;
            r_em_y      <= r_dv_y;
            r_em_addr   <= r_dv_base + 25'(r_dv_x);
            r_em_bits   <= r_dv_bits;
            r_em_qx     <= w_qx;
            r_em_rx     <= w_rx;
            r_em_qa     <= w_qc[7:0];
            r_em_ra     <= w_rc;
            r_em_qy     <= w_qy;
            r_em_line   <= r_dv_line;
            r_em_cursor <= r_dv_cursor;
        end else if (w_fire) begin
            r_em_p    <= r_em_p + 1'b1;
            r_em_x    <= r_em_x + 1'b1;
            r_em_addr <= r_em_addr + 1'b1;
            r_em_bits <= {r_em_bits[14:0], 1'b0};
            // step the red quotient by 128/width, carrying the remainder
            if (w_rsum >= {1'b0, w_w}) begin
                r_em_rx <= DW'(w_rsum - {1'b0, w_w});
                r_em_qx <= r_em_qx + NW'(r_em_qa) + 1'b1;
            end else begin
                r_em_rx <= w_rsum[DW-1:0];
                r_em_qx <= r_em_qx + NW'(r_em_qa);
            end
        end
    end

    always_comb begin
        w_red_sum  = (NW + 1)'(r_em_qx) +
                     (NW + 1)'((i_mode == tcgr_pkg::MODE_RED) ? tcgr_pkg::COLOR_OFS : 8'd0);
        w_blue_sum = (NW + 1)'(r_em_qy) +
                     (NW + 1)'((i_mode == tcgr_pkg::MODE_BLUE) ? tcgr_pkg::COLOR_OFS : 8'd0);
        w_red      = (w_red_sum > (NW + 1)'(255)) ? 8'hff : w_red_sum[7:0];
        w_blue     = (w_blue_sum > (NW + 1)'(255)) ? 8'hff : w_blue_sum[7:0];
        w_green    = (i_mode == tcgr_pkg::MODE_GREEN) ? tcgr_pkg::COLOR_OFS : 8'd0;
        w_fg       = (i_mode == tcgr_pkg::MODE_SOLID) ? tcgr_pkg::FG_WHITE : tcgr_pkg::FG_GREEN;
        w_bg       = (i_mode == tcgr_pkg::MODE_SOLID) ? tcgr_pkg::BG_BLUE
                                                      : {w_red, w_green, w_blue};
        w_outline  = r_em_cursor && ((r_em_line == 4'd0) || (r_em_line == 4'd15) ||
                                     (r_em_p == 4'd0) || (r_em_p == 4'd15));
        w_color    = (r_em_bits[15] || w_outline) ? w_fg : w_bg;
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_item <= '{pixel_x: r_em_x, pixel_y: r_em_y, word_address: r_em_addr,
                            color: w_color, last: (r_em_p == 4'd15)};
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

endmodule

`default_nettype wire

@@ rtl/core/text_cell_glyph_renderer.sv @@
// ----------------------------------------------------------------------------
// text_cell_glyph_renderer
// text mode character generator: font store plus 16x16 cell line renderer
// ----------------------------------------------------------------------------
// latency: a load item is written to the font store as it is accepted; the first
//   pixel of a render item follows its glyph lookup, job queue and gradient division
// throughput: one load item per cycle while o_stall is low; a render item occupies
//   the pixel port for its 16 pixels, one pixel per cycle while i_stall is low
// reset: registers return to 1024x768, pitch 1024, mode 0, cursor at 0,0;
//   the font store is not cleared and holds garbage until written
`default_nettype none

module text_cell_glyph_renderer #(
    parameter int FONT_GLYPHS = tcgr_pkg::FONT_GLYPHS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // request channel
    input  wire logic                i_valid,
    output      logic                o_stall,
    input  wire tcgr_pkg::t_in_item  i_item,
    // pixel channel
    output      logic                o_valid,
    input  wire logic                i_stall,
    output      tcgr_pkg::t_out_item o_item,
    // register port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [4:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output      logic [31:0]         prdata,
    output      logic                pready
);

    // ------------------------------------------------------------------
    // register file
    // ------------------------------------------------------------------
    logic [11:0] r_fb_width;
    logic [11:0] r_fb_height;
    logic [12:0] r_pitch;
    logic [2:0]  r_mode;
    logic [7:0]  r_cur_row;
    logic [7:0]  r_cur_col;
    logic        w_wr;
    tcgr_pkg::t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    // registers sit on word addresses; low address bits are ignored
    assign w_idx  = tcgr_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_width  <= tcgr_pkg::RST_FB_WIDTH;
            r_fb_height <= tcgr_pkg::RST_FB_HEIGHT;
            r_pitch     <= tcgr_pkg::RST_PITCH;
            r_mode      <= tcgr_pkg::MODE_PLAIN;
            r_cur_row   <= 8'd0;
            r_cur_col   <= 8'd0;
        end else if (w_wr) begin
            case (w_idx)
                tcgr_pkg::REG_FB_WIDTH:      r_fb_width  <= pwdata[11:0];
                tcgr_pkg::REG_FB_HEIGHT:     r_fb_height <= pwdata[11:0];
                tcgr_pkg::REG_PITCH_WORDS:   r_pitch     <= pwdata[12:0];
                tcgr_pkg::REG_PALETTE_MODE:  r_mode      <= pwdata[2:0];
                tcgr_pkg::REG_CURSOR_ROW:    r_cur_row   <= pwdata[7:0];
                tcgr_pkg::REG_CURSOR_COLUMN: r_cur_col   <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            tcgr_pkg::REG_FB_WIDTH:      prdata = {20'd0, r_fb_width};
            tcgr_pkg::REG_FB_HEIGHT:     prdata = {20'd0, r_fb_height};
            tcgr_pkg::REG_PITCH_WORDS:   prdata = {19'd0, r_pitch};
            tcgr_pkg::REG_PALETTE_MODE:  prdata = {29'd0, r_mode};
            tcgr_pkg::REG_CURSOR_ROW:    prdata = {24'd0, r_cur_row};
            tcgr_pkg::REG_CURSOR_COLUMN: prdata = {24'd0, r_cur_col};
            default:                     prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // front: font writes and glyph line lookup, feeding the job queue
    // ------------------------------------------------------------------
    logic                          w_push;
    tcgr_pkg::t_job                w_push_job;
    logic                          w_pop;
    tcgr_pkg::t_job                w_head_job;
    logic                          w_q_valid;
    logic [tcgr_pkg::QCOUNT_W-1:0] w_q_count;

    tcgr_front #(
        .FONT_GLYPHS (FONT_GLYPHS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_item    (i_item),
        .i_q_count (w_q_count),
        .o_push    (w_push),
        .o_job     (w_push_job)
    );

    // queue decouples lookup from the pixel stream
    tcgr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_valid (w_q_valid),
        .o_count (w_q_count)
    );

    // ------------------------------------------------------------------
    // back: gradient division overlaps emission of the previous line
    // ------------------------------------------------------------------
    tcgr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_job     (w_head_job),
        .o_q_pop     (w_pop),
        .i_fb_width  (r_fb_width),
        .i_fb_height (r_fb_height),
        .i_pitch     (r_pitch),
        .i_mode      (r_mode),
        .i_cur_row   (r_cur_row),
        .i_cur_col   (r_cur_col),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item)
    );

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // the last pixel of a line always lands on the right edge of the cell
    a_last_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.last |-> (o_item.pixel_x[3:0] == 4'hf))
        else $error("last pixel not on cell edge");

    // pixels within a line follow with no gap once taken
    a_line_dense: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item.last && !i_stall |=> o_valid)
        else $error("gap inside a pixel line");

    // the queue never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_count <= tcgr_pkg::QCOUNT_W'(tcgr_pkg::QUEUE_DEPTH))
        else $error("job queue overflow");

    // nothing is pushed while the queue is full and not draining
    a_queue_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_count == tcgr_pkg::QCOUNT_W'(tcgr_pkg::QUEUE_DEPTH)) && !w_pop |-> !w_push)
        else $error("push into full queue");

endmodule

`default_nettype wire

@@ tb/sv/text_cell_glyph_renderer_test.sv @@
// ----------------------------------------------------------------------------
// text_cell_glyph_renderer_test
// self-checking bench for the text cell glyph renderer: directed table plus
// random loads and renders, checked pixel by pixel against a local predictor
// ----------------------------------------------------------------------------
`default_nettype none

module text_cell_glyph_renderer_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int FILL_GLYPHS  = 8;
    localparam int STORE_DEPTH  = tcgr_pkg::FONT_GLYPHS * tcgr_pkg::CELL_SIZE;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    tcgr_pkg::t_in_item  i_item = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    tcgr_pkg::t_out_item o_item;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [4:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    text_cell_glyph_renderer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state: shadow registers and font
    logic [11:0] fb_width_q;
    logic [11:0] fb_height_q;
    logic [12:0] pitch_q;
    logic [2:0]  mode_q;
    logic [7:0]  cur_row_q;
    logic [7:0]  cur_col_q;
    logic [15:0] font_q [STORE_DEPTH];

    tcgr_pkg::t_out_item pixel_queue [$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          rx_hold = 1'b0;   // long receiver hold-off request

    // directed rows: the item, plus a typed pixel-0 color where obvious
    typedef struct {
        tcgr_pkg::t_in_item item;
        bit                 has_color;
        logic [23:0]        color0;
    } t_row;

    function automatic logic [7:0] sat8(input logic [31:0] v);
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [23:0] fg_of();
        return (mode_q == tcgr_pkg::MODE_SOLID) ? tcgr_pkg::FG_WHITE : tcgr_pkg::FG_GREEN;
    endfunction

    function automatic logic [23:0] bg_of(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] r;
        logic [31:0] g;
        logic [31:0] b;
        w = (fb_width_q == 0) ? 1 : fb_width_q;
        h = (fb_height_q == 0) ? 1 : fb_height_q;
        if (mode_q == tcgr_pkg::MODE_SOLID)
            return tcgr_pkg::BG_BLUE;
        r = ((mode_q == tcgr_pkg::MODE_RED) ? 60 : 0) + x * 128 / w;
        g = (mode_q == tcgr_pkg::MODE_GREEN) ? 60 : 0;
        b = ((mode_q == tcgr_pkg::MODE_BLUE) ? 60 : 0) + y * 128 / h;
        return {sat8(r), sat8(g), sat8(b)};
    endfunction

    // expected pixels of one accepted request
    task automatic predict_pixels(input tcgr_pkg::t_in_item it);
        logic [7:0]  glyph;
        logic [15:0] lbits;
        logic [31:0] x;
        logic [31:0] y;
        logic [23:0] c;
        logic [63:0] addr;
        bit          on_cur;
        tcgr_pkg::t_out_item px;
        if (it.opcode == tcgr_pkg::OP_LOAD) begin
            if (it.glyph_index < tcgr_pkg::FONT_GLYPHS)
                font_q[it.glyph_index*tcgr_pkg::CELL_SIZE + it.glyph_line] = it.font_bits;
            return;
        end
        glyph = (it.char_code < 32 || it.char_code > 127) ? 8'd0 : it.char_code - 8'd32;
        if (glyph >= tcgr_pkg::FONT_GLYPHS)
            glyph = 0;
        lbits = font_q[glyph*tcgr_pkg::CELL_SIZE + it.glyph_line];
        y = 16 * it.cell_row + it.glyph_line;
        on_cur = (it.cell_row == cur_row_q) && (it.cell_column == cur_col_q);
        for (int p = 0; p < 16; p++) begin
            x = 16 * it.cell_column + p;
            c = lbits[15-p] ? fg_of() : bg_of(x, y);
            if (on_cur && (it.glyph_line == 0 || it.glyph_line == 15 || p == 0 || p == 15))
                c = fg_of();
            addr = y * pitch_q + x;
            px.pixel_x = x[11:0];
            px.pixel_y = y[11:0];
            px.word_address = addr[24:0];
            px.color = c;
            px.last = (p == 15);
            pixel_queue.push_back(px);
        end
    endtask

    // send one request, wait for acceptance
    task automatic send_request(input tcgr_pkg::t_in_item it);
        i_item <= it;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        predict_pixels(it);
        @(negedge i_clk);
    endtask

    task automatic drop_valid();
        i_valid <= 1'b0;
    endtask

    task automatic reg_write(input tcgr_pkg::t_reg_idx idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx) << 2;
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            tcgr_pkg::REG_FB_WIDTH:      fb_width_q = val[11:0];
            tcgr_pkg::REG_FB_HEIGHT:     fb_height_q = val[11:0];
            tcgr_pkg::REG_PITCH_WORDS:   pitch_q = val[12:0];
            tcgr_pkg::REG_PALETTE_MODE:  mode_q = val[2:0];
            tcgr_pkg::REG_CURSOR_ROW:    cur_row_q = val[7:0];
            tcgr_pkg::REG_CURSOR_COLUMN: cur_col_q = val[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // block idle before register writes
    task automatic wait_idle();
        drop_valid();
        while (pixel_queue.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input logic [11:0] w, input logic [11:0] h, input logic [12:0] pw,
                             input logic [2:0] m, input logic [7:0] cr, input logic [7:0] cc);
        wait_idle();
        reg_write(tcgr_pkg::REG_FB_WIDTH, 32'(w));
        reg_write(tcgr_pkg::REG_FB_HEIGHT, 32'(h));
        reg_write(tcgr_pkg::REG_PITCH_WORDS, 32'(pw));
        reg_write(tcgr_pkg::REG_PALETTE_MODE, 32'(m));
        reg_write(tcgr_pkg::REG_CURSOR_ROW, 32'(cr));
        reg_write(tcgr_pkg::REG_CURSOR_COLUMN, 32'(cc));
    endtask

    function automatic tcgr_pkg::t_in_item load_req(input int g, input int ln,
                                                    input logic [15:0] b);
        tcgr_pkg::t_in_item it;
        it = tcgr_pkg::t_in_item'(52'({$urandom, $urandom}));
        it.opcode = tcgr_pkg::OP_LOAD;
        it.glyph_index = 7'(g);
        it.glyph_line = 4'(ln);
        it.font_bits = b;
        return it;
    endfunction

    function automatic tcgr_pkg::t_in_item render_req(input int code, input int r, input int c,
                                                      input int ln);
        tcgr_pkg::t_in_item it;
        it = tcgr_pkg::t_in_item'(52'({$urandom, $urandom}));
        it.opcode = tcgr_pkg::OP_RENDER;
        it.char_code = 8'(code);
        it.cell_row = 8'(r);
        it.cell_column = 8'(c);
        it.glyph_line = 4'(ln);
        return it;
    endfunction

    task automatic fill_glyph(input int g);
        for (int ln = 0; ln < tcgr_pkg::CELL_SIZE; ln++)
            send_request(load_req(g, ln, (g == 0) ? 16'h0000 : 16'($urandom)));
    endtask

    // glyphs 0..7, 33 and 95 are written first; renders only use those
    task automatic fill_font();
        for (int g = 0; g < FILL_GLYPHS; g++)
            fill_glyph(g);
        fill_glyph(33);
        fill_glyph(95);
        drop_valid();
    endtask

    // a character code whose glyph has been written
    function automatic int filled_code();
        int k;
        k = $urandom_range(0, 3);
        if (k == 0)
            return $urandom_range(32, 32 + FILL_GLYPHS - 1);
        if (k == 1)
            return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 31)
                                               : $urandom_range(128, 255);
        if (k == 2)
            return 65;
        return 127;
    endfunction

    // random request: well-formed renders mostly, some loads and odd codes
    function automatic tcgr_pkg::t_in_item random_req();
        int k;
        k = $urandom_range(0, 9);
        if (k < 2)
            return load_req($urandom_range(0, 127), $urandom_range(0, 15), 16'($urandom));
        if (k == 2)
            return render_req(filled_code(), $urandom_range(0, 255),
                              $urandom_range(0, 255), $urandom_range(0, 15));
        if (k == 3)
            return render_req(filled_code(), cur_row_q, cur_col_q,
                              $urandom_range(0, 15));
        return render_req(filled_code(), $urandom_range(0, 63),
                          $urandom_range(0, 63), $urandom_range(0, 15));
    endfunction

    // sender with bursts and gaps
    task automatic random_phase(input int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && n > 0) begin
                send_request(random_req());
                burst--;
                n--;
            end
            if ($urandom_range(0, 2) != 0) begin
                drop_valid();
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end
        end
    endtask

    // receiver stall pattern, with the long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else if (rx_hold)
            i_stall <= 1'b1;
        else if ((cycles / 300) % 3 == 0)
            i_stall <= 1'b0;
        else
            i_stall <= ($urandom_range(0, 3) == 0);
    end

    // pixel check at the rising edge
    always @(posedge i_clk) begin
        tcgr_pkg::t_out_item exp_px;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixel_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel %h", o_item);
            end else begin
                exp_px = pixel_queue.pop_front();
                if (exp_px.pixel_x !== o_item.pixel_x || exp_px.pixel_y !== o_item.pixel_y
                    || exp_px.word_address !== o_item.word_address
                    || exp_px.color !== o_item.color || exp_px.last !== o_item.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: exp x=%0d y=%0d a=%h c=%h l=%b, got x=%0d y=%0d a=%h c=%h l=%b",
                                 exp_px.pixel_x, exp_px.pixel_y, exp_px.word_address,
                                 exp_px.color, exp_px.last, o_item.pixel_x, o_item.pixel_y,
                                 o_item.word_address, o_item.color, o_item.last);
                end
            end
        end
    end

    // generous cycle limit
    always @(posedge i_clk) begin
        if (cycles >= LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // directed table
    t_row directed [$];

    task automatic run_directed();
        tcgr_pkg::t_in_item it;
        t_row rw;
        // reset colors: glyph 0 blank, mode 0 gradient; cell (1,1) line 7 starts at 2,0,3
        rw.item = render_req(0, 1, 1, 7);  rw.has_color = 1; rw.color0 = 24'h020003;
        directed.push_back(rw);
        rw.item = render_req(255, 2, 3, 4); rw.has_color = 0; directed.push_back(rw);
        rw.item = render_req(31, 0, 0, 0);  directed.push_back(rw);  // cursor top line
        rw.item = render_req(32, 0, 0, 15); directed.push_back(rw);
        rw.item = render_req(127, 255, 255, 15); directed.push_back(rw);
        rw.item = render_req(128, 255, 0, 8); directed.push_back(rw);
        rw.item = load_req(127, 3, 16'hffff); directed.push_back(rw); // ignored slot
        rw.item = load_req(96, 3, 16'hffff); directed.push_back(rw);
        rw.item = load_req(95, 15, 16'h8001); directed.push_back(rw);
        rw.item = render_req(127, 10, 10, 15); directed.push_back(rw);
        rw.item = render_req(33, 0, 255, 9); directed.push_back(rw);
        rw.item = render_req(65, 255, 0, 0); directed.push_back(rw);
        rw.item = load_req(0, 0, 16'h0000); directed.push_back(rw);
        // cell (7,7) line 0 starts at 14,0,18
        rw.item = render_req(1, 7, 7, 0); rw.has_color = 1; rw.color0 = 24'h0e0012;
        directed.push_back(rw);
        foreach (directed[i]) begin
            it = directed[i].item;
            send_request(it);
            if (directed[i].has_color && pixel_queue.size() >= 16
                && pixel_queue[pixel_queue.size()-16].color !== directed[i].color0
                && !(it.cell_row == cur_row_q && it.cell_column == cur_col_q)) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("directed row %0d color: exp %h, got %h", i,
                             directed[i].color0, pixel_queue[pixel_queue.size()-16].color);
            end
        end
        drop_valid();
    endtask

    initial begin
        fb_width_q = tcgr_pkg::RST_FB_WIDTH;
        fb_height_q = tcgr_pkg::RST_FB_HEIGHT;
        pitch_q = tcgr_pkg::RST_PITCH;
        mode_q = tcgr_pkg::MODE_PLAIN;
        cur_row_q = 0;
        cur_col_q = 0;
        foreach (font_q[i])
            font_q[i] = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        fill_font();
        run_directed();

        // extreme settings, then a mix; writes only when idle
        configure(12'd1, 12'd1, 13'd8191, tcgr_pkg::MODE_RED, 8'd255, 8'd255);
        random_phase(40);
        configure(12'd4095, 12'd4095, 13'd1, tcgr_pkg::MODE_SOLID, 8'd3, 8'd5);
        random_phase(40);
        configure(12'd0, 12'd0, 13'd0, 3'd7, 8'd0, 8'd0);
        random_phase(30);
        configure(12'd640, 12'd480, 13'd640, tcgr_pkg::MODE_GREEN, 8'd10, 8'd20);

        // long receiver hold-off while requests keep coming
        rx_hold = 1'b1;
        fork
            random_phase(12);
            begin
                repeat (400) @(negedge i_clk);
                rx_hold = 1'b0;
            end
        join
        random_phase(70);
        configure(12'd100, 12'd37, 13'd4097, tcgr_pkg::MODE_BLUE, 8'd1, 8'd2);
        random_phase(70);
        configure(12'd2048, 12'd1024, 13'd2048, tcgr_pkg::MODE_PLAIN, 8'd0, 8'd63);
        random_phase(44);

        drop_valid();
        while (pixel_queue.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // a pixel left over at the end holds the drain loop until the cycle limit reports a mismatch;
    // unexpected pixels during drain are caught by the checker
endmodule

`default_nettype wire
